// ===== rtl/eno_pkg.sv =====
// ----------------------------------------------------------------------------
// eno_pkg: shared types and constants of the ENO upwind advection core
// Sizes of the fixed-point datapath, the divisor code and the queue item.
// ----------------------------------------------------------------------------
package eno_pkg;

    localparam int DataWidth  = 32;
    localparam int FracBits   = 16;
    localparam int NumWidth   = 40;                    // derivative numerator, signed
    localparam int DmagWidth  = NumWidth - 1;          // magnitude of numerator / 2
    localparam int InvWidth   = 31;
    localparam int BandWidth  = 31;
    localparam int Prod1Width = DmagWidth + InvWidth;  // |D| * inverse_spacing
    localparam int DerWidth   = Prod1Width - FracBits + 1;
    localparam int Prod2Width = DerWidth + DataWidth;  // |deriv| * |velocity|
    localparam int CntWidth   = 6;
    localparam int CfgIdxWidth = 2;

    // divide by three: chunks of the magnitude, each by reciprocal multiply
    localparam int DivChunk   = 13;                    // dividend bits per step
    localparam int DivSteps   = DmagWidth / DivChunk;
    localparam int RecipWidth = DivChunk + 2;          // remainder and chunk
    localparam int RecipShift = 16;
    localparam logic [RecipWidth-1:0] RecipThird = 15'd21846;  // ceil(2^16 / 3)

    // register indexes of the configuration port
    localparam logic [CfgIdxWidth-1:0] CfgOrder   = 2'd0;
    localparam logic [CfgIdxWidth-1:0] CfgInvSpc  = 2'd1;
    localparam logic [CfgIdxWidth-1:0] CfgBandHw  = 2'd2;

    localparam logic [1:0]           OrderResetVal = 2'd1;
    localparam logic [InvWidth-1:0]  InvResetVal   = 31'd65536;
    localparam logic [BandWidth-1:0] BandResetVal  = 31'd196608;

    // divisor of the numerator: 1, 2 or 6 by scheme order
    typedef enum logic [1:0] {
        KDIV_1,
        KDIV_2,
        KDIV_6
    } kdiv_t;

    // item handed from the classifier to the arithmetic sequencer
    typedef struct packed {
        logic signed [NumWidth-1:0]  num;
        kdiv_t                       kdiv;
        logic signed [DataWidth-1:0] vel;
        logic                        band;
    } eno_item_t;

    typedef enum logic [3:0] {
        BK_IDLE,
        BK_DIV,
        BK_SET1,
        BK_MUL1,
        BK_SET2,
        BK_MUL2,
        BK_FIN,
        BK_OUT
    } bk_state_t;

endpackage

// ===== rtl/eno_front.sv =====
// ----------------------------------------------------------------------------
// eno_front: sample window, band test and ENO stencil selection
// Shifts each sample into the window, then forms the exact derivative
// numerator of the chosen order and hands it to the queue.
// ----------------------------------------------------------------------------
module eno_front
(
    input  logic                              clk,
    input  logic                              rst_n,
    input  logic                              s_tvalid,
    output logic                              s_tready,
    input  logic [3*eno_pkg::DataWidth-1:0]   s_tdata,
    input  logic                              s_tuser,
    input  logic [1:0]                        scheme_order,
    input  logic [eno_pkg::BandWidth-1:0]     band_half_width,
    input  logic                              q_full,
    output logic                              q_push,
    output eno_pkg::eno_item_t                q_item
);

    localparam int DW = eno_pkg::DataWidth;
    localparam int NW = eno_pkg::NumWidth;

    logic signed [DW-1:0] win_reg [7];
    logic signed [DW-1:0] vel_reg;
    logic                 band_reg;
    logic                 pend_reg;

    logic                 accept;
    logic signed [DW-1:0] cell_dist;
    logic [DW-1:0]        dist_mag;
    logic                 band_now;
    logic signed [NW-1:0] w [7];
    logic signed [NW-1:0] d2mid, l2u, l2d, t3c, t3d, t3uu, t3dd, num;
    logic                 up;

    function automatic logic [NW-1:0] amag(input logic signed [NW-1:0] a);
        amag = a[NW-1] ? -a : a;
    endfunction

    function automatic logic signed [NW-1:0] minmag(input logic signed [NW-1:0] a,
                                                    input logic signed [NW-1:0] b);
        minmag = (amag(a) < amag(b)) ? a : b;
    endfunction

    assign accept   = s_tvalid && s_tready;
    assign q_push   = pend_reg && !q_full;
    assign s_tready = !pend_reg || !q_full;

    // band test on the incoming distance
    assign cell_dist = s_tdata[3*DW-1:2*DW];
    assign dist_mag  = cell_dist[DW-1] ? -cell_dist : cell_dist;
    assign band_now  = s_tuser && (dist_mag <= {1'b0, band_half_width});

    // shift the window and hold the cell fields
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            for (int i = 0; i < 7; i++)
            begin
                win_reg[i] <= '0;
            end
            pend_reg <= 1'b0;
        end
        else
        begin
            if (accept)
            begin
                for (int i = 0; i < 6; i++)
                begin
                    win_reg[i] <= win_reg[i+1];
                end
                win_reg[6] <= s_tdata[DW-1:0];
                pend_reg   <= 1'b1;
            end
            else if (q_push)
            begin
                pend_reg <= 1'b0;
            end
        end
    end

    always_ff @(posedge clk)
    begin
        if (accept)
        begin
            vel_reg  <= s_tdata[2*DW-1:DW];
            band_reg <= band_now;
        end
    end

    // stencil numerator of the selected order
    always_comb
    begin
        for (int i = 0; i < 7; i++)
        begin
            w[i] = NW'(win_reg[i]);
        end
        up    = !vel_reg[DW-1] && (vel_reg != '0);
        d2mid = w[2] - (w[3] <<< 1) + w[4];
        l2u   = w[1] - (w[2] <<< 1) + w[3];
        l2d   = w[3] - (w[4] <<< 1) + w[5];
        t3c   = w[4] - w[1] + 3 * (w[2] - w[3]);
        t3d   = w[5] - w[2] + 3 * (w[3] - w[4]);
        t3uu  = w[3] - w[0] + 3 * (w[1] - w[2]);
        t3dd  = w[6] - w[3] + 3 * (w[4] - w[5]);
        q_item.kdiv = eno_pkg::KDIV_1;
        case (scheme_order)
            2'd2:
            begin
                q_item.kdiv = eno_pkg::KDIV_2;
                if (up)
                    num = ((w[3] - w[2]) <<< 1) + minmag(l2u, d2mid);
                else
                    num = ((w[4] - w[3]) <<< 1) - minmag(l2d, d2mid);
            end
            2'd3:
            begin
                q_item.kdiv = eno_pkg::KDIV_6;
                if (up)
                begin
                    if (amag(l2u) <= amag(d2mid))
                        num = 6 * (w[3] - w[2]) + 3 * l2u + (minmag(t3uu, t3c) <<< 1);
                    else
                        num = 6 * (w[3] - w[2]) + 3 * d2mid - minmag(t3d, t3c);
                end
                else
                begin
                    if (amag(l2d) <= amag(d2mid))
                        num = 6 * (w[4] - w[3]) - 3 * l2d + (minmag(t3dd, t3d) <<< 1);
                    else
                        num = 6 * (w[4] - w[3]) - 3 * d2mid - minmag(t3c, t3d);
                end
            end
            default:
            begin
                num = up ? (w[3] - w[2]) : (w[4] - w[3]);
            end
        endcase
        q_item.num  = num;
        q_item.vel  = vel_reg;
        q_item.band = band_reg;
    end

endmodule

// ===== rtl/eno_queue.sv =====
// ----------------------------------------------------------------------------
// eno_queue: two-entry queue between classifier and sequencer
// Lets the front keep taking samples while the back works on an item.
// ----------------------------------------------------------------------------
module eno_queue
(
    input  logic               clk,
    input  logic               rst_n,
    input  logic               push,
    input  eno_pkg::eno_item_t push_item,
    output logic               full,
    input  logic               pop,
    output logic               avail,
    output eno_pkg::eno_item_t head
);

    eno_pkg::eno_item_t mem [2];
    logic               wr_ptr_reg;
    logic               rd_ptr_reg;
    logic [1:0]         cnt_reg;

    assign full  = (cnt_reg == 2'd2);
    assign avail = (cnt_reg != 2'd0);
    assign head  = mem[rd_ptr_reg];

    // store pushed items
    always_ff @(posedge clk)
    begin
        if (push)
        begin
            mem[wr_ptr_reg] <= push_item;
        end
    end

    // advance pointers and count
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            wr_ptr_reg <= 1'b0;
            rd_ptr_reg <= 1'b0;
            cnt_reg    <= 2'd0;
        end
        else
        begin
            if (push)
                wr_ptr_reg <= !wr_ptr_reg;
            if (pop)
                rd_ptr_reg <= !rd_ptr_reg;
            if (push && !pop)
                cnt_reg <= cnt_reg + 2'd1;
            else if (pop && !push)
                cnt_reg <= cnt_reg - 2'd1;
        end
    end

endmodule

// ===== rtl/eno_back.sv =====
// ----------------------------------------------------------------------------
// eno_back: division, scaling and velocity product sequencer
// For an in-band item, divides the numerator by its order factor, multiplies by inverse spacing
// and by velocity with shift-add steps, floors and saturates the result; an item out of band gives zero.
// ----------------------------------------------------------------------------
module eno_back
(
    input  logic                          clk,
    input  logic                          rst_n,
    input  logic                          q_avail,
    input  eno_pkg::eno_item_t            q_head,
    output logic                          q_pop,
    input  logic [eno_pkg::InvWidth-1:0]  inverse_spacing,
    output logic                          m_tvalid,
    input  logic                          m_tready,
    output logic [eno_pkg::DataWidth-1:0] m_tdata,
    output logic                          m_tuser
);

    localparam int DW  = eno_pkg::DataWidth;
    localparam int FB  = eno_pkg::FracBits;
    localparam int NW  = eno_pkg::NumWidth;
    localparam int MW  = eno_pkg::DmagWidth;
    localparam int P1W = eno_pkg::Prod1Width;
    localparam int DVW = eno_pkg::DerWidth;
    localparam int P2W = eno_pkg::Prod2Width;
    localparam int CW  = eno_pkg::CntWidth;
    localparam int DC  = eno_pkg::DivChunk;
    localparam int RW  = eno_pkg::RecipWidth;
    localparam int RS  = eno_pkg::RecipShift;
    localparam logic [P2W-FB-1:0] PosMax = (P2W-FB)'({1'b0, {(DW-1){1'b1}}});
    localparam logic [P2W-FB-1:0] NegMax = (P2W-FB)'({1'b1, {(DW-1){1'b0}}});

    eno_pkg::bk_state_t   st_reg, st_next;
    logic [CW-1:0]        cnt_reg, cnt_next;
    logic [MW-1:0]        mag_reg, mag_next;
    logic [1:0]           rem_reg, rem_next;
    logic                 dneg_reg, dneg_next;
    logic signed [DW-1:0] vel_reg, vel_next;
    logic                 band_reg, band_next;
    logic [P2W-1:0]       acc_reg, acc_next;
    logic [P2W-1:0]       mcand_reg, mcand_next;
    logic [DW-1:0]        mplier_reg, mplier_next;
    logic [DW-1:0]        res_reg, res_next;
    logic [DW-1:0]        tdata_reg;
    logic                 tuser_reg;
    logic                 tvalid_reg, tvalid_next;
    logic                 load_out;

    logic signed [NW-1:0] half;
    logic [NW-1:0]        half_mag;
    logic [RW-1:0]        div_v;
    logic [2*RW-1:0]      div_prod;
    logic [DC-1:0]        div_q;
    logic [RW-1:0]        div_r;
    logic [MW-1:0]        dmag;
    logic [DVW-1:0]       der_mag;
    logic [P2W-FB-1:0]    qv;
    logic                 tneg;
    logic [DW-1:0]        vel_mag;

    assign load_out = (st_reg == eno_pkg::BK_OUT) && (!tvalid_reg || m_tready);
    assign q_pop    = (st_reg == eno_pkg::BK_IDLE) && q_avail;
    assign m_tvalid = tvalid_reg;
    assign m_tdata  = tdata_reg;
    assign m_tuser  = tuser_reg;

    // next state
    always_comb
    begin
        st_next = st_reg;
        case (st_reg)
            eno_pkg::BK_IDLE:
            begin
                if (q_avail)
                begin
                    if (!q_head.band)
                        st_next = eno_pkg::BK_OUT;
                    else if (q_head.kdiv == eno_pkg::KDIV_6)
                        st_next = eno_pkg::BK_DIV;
                    else
                        st_next = eno_pkg::BK_SET1;
                end
            end
            eno_pkg::BK_DIV:
                if (cnt_reg == CW'(1))
                    st_next = eno_pkg::BK_SET1;
            eno_pkg::BK_SET1:
                st_next = eno_pkg::BK_MUL1;
            eno_pkg::BK_MUL1:
                if (cnt_reg == CW'(1))
                    st_next = eno_pkg::BK_SET2;
            eno_pkg::BK_SET2:
                st_next = eno_pkg::BK_MUL2;
            eno_pkg::BK_MUL2:
                if (cnt_reg == CW'(1))
                    st_next = eno_pkg::BK_FIN;
            eno_pkg::BK_FIN:
                st_next = eno_pkg::BK_OUT;
            eno_pkg::BK_OUT:
                if (load_out)
                    st_next = eno_pkg::BK_IDLE;
            default:
                st_next = eno_pkg::BK_IDLE;
        endcase
    end

    // datapath
    always_comb
    begin
        cnt_next    = cnt_reg;
        mag_next    = mag_reg;
        rem_next    = rem_reg;
        dneg_next   = dneg_reg;
        vel_next    = vel_reg;
        band_next   = band_reg;
        acc_next    = acc_reg;
        mcand_next  = mcand_reg;
        mplier_next = mplier_reg;
        res_next    = res_reg;
        half     = (q_head.kdiv == eno_pkg::KDIV_1) ? q_head.num : (q_head.num >>> 1);
        half_mag = half[NW-1] ? -half : half;
        div_v    = {rem_reg, mag_reg[MW-1 -: DC]};
        div_prod = (2*RW)'(div_v) * (2*RW)'(eno_pkg::RecipThird);
        div_q    = div_prod[RS+DC-1:RS];
        div_r    = div_v - ((RW'(div_q) << 1) + RW'(div_q));
        dmag     = mag_reg + MW'(dneg_reg && (rem_reg != 2'd0));
        der_mag  = DVW'(acc_reg[P1W-1:FB]) + DVW'(dneg_reg && (acc_reg[FB-1:0] != '0));
        vel_mag  = vel_reg[DW-1] ? -vel_reg : vel_reg;
        tneg     = vel_reg[DW-1] != dneg_reg;
        qv       = acc_reg[P2W-1:FB] + (P2W-FB)'(tneg && (acc_reg[FB-1:0] != '0));
        case (st_reg)
            eno_pkg::BK_IDLE:
            begin
                if (q_avail)
                begin
                    vel_next  = q_head.vel;
                    band_next = q_head.band;
                    mag_next  = half_mag[MW-1:0];
                    dneg_next = half[NW-1];
                    rem_next  = 2'd0;
                    cnt_next  = CW'(eno_pkg::DivSteps);
                    res_next  = '0;
                end
            end
            eno_pkg::BK_DIV:
            begin
                // divide one chunk by three, carry the remainder to the next
                rem_next = div_r[1:0];
                mag_next = {mag_reg[MW-DC-1:0], div_q};
                cnt_next = cnt_reg - CW'(1);
            end
            eno_pkg::BK_SET1:
            begin
                acc_next    = '0;
                mcand_next  = P2W'(dmag);
                mplier_next = DW'(inverse_spacing);
                cnt_next    = CW'(eno_pkg::InvWidth);
            end
            eno_pkg::BK_SET2:
            begin
                acc_next    = '0;
                mcand_next  = P2W'(der_mag);
                mplier_next = vel_mag;
                cnt_next    = CW'(DW);
            end
            eno_pkg::BK_MUL1, eno_pkg::BK_MUL2:
            begin
                if (mplier_reg[0])
                    acc_next = acc_reg + mcand_reg;
                mcand_next  = mcand_reg << 1;
                mplier_next = mplier_reg >> 1;
                cnt_next    = cnt_reg - CW'(1);
            end
            eno_pkg::BK_FIN:
            begin
                // floor and saturate the velocity product
                if (!tneg)
                    res_next = (qv > PosMax) ? PosMax[DW-1:0] : qv[DW-1:0];
                else if (qv > NegMax)
                    res_next = NegMax[DW-1:0];
                else
                    res_next = -qv[DW-1:0];
            end
            default:
            begin
            end
        endcase
    end

    // output register valid
    always_comb
    begin
        tvalid_next = tvalid_reg;
        if (load_out)
            tvalid_next = 1'b1;
        else if (m_tready)
            tvalid_next = 1'b0;
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            st_reg     <= eno_pkg::BK_IDLE;
            tvalid_reg <= 1'b0;
        end
        else
        begin
            st_reg     <= st_next;
            tvalid_reg <= tvalid_next;
        end
    end

    always_ff @(posedge clk)
    begin
        cnt_reg    <= cnt_next;
        mag_reg    <= mag_next;
        rem_reg    <= rem_next;
        dneg_reg   <= dneg_next;
        vel_reg    <= vel_next;
        band_reg   <= band_next;
        acc_reg    <= acc_next;
        mcand_reg  <= mcand_next;
        mplier_reg <= mplier_next;
        res_reg    <= res_next;
        if (load_out)
        begin
            tdata_reg <= res_reg;
            tuser_reg <= band_reg;
        end
    end

endmodule

// ===== rtl/eno_upwind_advection_stencil_core.sv =====
// ----------------------------------------------------------------------------
// eno_upwind_advection_stencil_core: upwind ENO advection term, one row
// Streams level-set samples through a seven-sample window and returns one
// saturated Q16.16 velocity times derivative term per sample.
// ----------------------------------------------------------------------------
//  channel  | direction | content
//  s_axis   | in        | tdata: phi_sample, velocity, band_distance; tuser: cell_valid
//  m_axis   | out       | tdata: rate_term; tuser: in_band
//  cfg      | in        | cfg_addr 0 scheme_order, 1 inverse_spacing, 2 band_half_width
//
//  An item out of band goes straight to the output of the sequencer; an in-band
//  item passes through the three-step chunked divide by three, at order 3 only,
//  and through the two shift-add multipliers; the sequencer works on one item at a time.
//  The front and a two-entry queue take up to three samples ahead of the back.
//  Reset clears the window and the queue and sets the configuration registers to their defaults.
//  Either side may stall at any time; the output register holds its item.
// ----------------------------------------------------------------------------
module eno_upwind_advection_stencil_core
(
    input  logic                                  clk,
    input  logic                                  rst_n,
    input  logic                                  s_tvalid,
    output logic                                  s_tready,
    input  logic [3*eno_pkg::DataWidth-1:0]       s_tdata,   // phi_sample, velocity, band_distance
    input  logic                                  s_tuser,   // cell_valid
    output logic                                  m_tvalid,
    input  logic                                  m_tready,
    output logic [eno_pkg::DataWidth-1:0]         m_tdata,   // rate_term
    output logic                                  m_tuser,   // in_band
    input  logic                                  cfg_we,
    input  logic [eno_pkg::CfgIdxWidth-1:0]       cfg_addr,
    input  logic [eno_pkg::InvWidth-1:0]          cfg_wdata
);

    logic [1:0]                    order_reg;
    logic [eno_pkg::InvWidth-1:0]  inv_reg;
    logic [eno_pkg::BandWidth-1:0] band_reg;

    logic               q_full;
    logic               q_push;
    logic               q_pop;
    logic               q_avail;
    eno_pkg::eno_item_t push_item;
    eno_pkg::eno_item_t head_item;

    // configuration registers
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            order_reg <= eno_pkg::OrderResetVal;
            inv_reg   <= eno_pkg::InvResetVal;
            band_reg  <= eno_pkg::BandResetVal;
        end
        else if (cfg_we)
        begin
            case (cfg_addr)
                eno_pkg::CfgOrder:  order_reg <= cfg_wdata[1:0];
                eno_pkg::CfgInvSpc: inv_reg   <= cfg_wdata;
                eno_pkg::CfgBandHw: band_reg  <= cfg_wdata;
                default:
                begin
                end
            endcase
        end
    end

    eno_front u_front
    (
        .clk             (clk),
        .rst_n           (rst_n),
        .s_tvalid        (s_tvalid),
        .s_tready        (s_tready),
        .s_tdata         (s_tdata),
        .s_tuser         (s_tuser),
        .scheme_order    (order_reg),
        .band_half_width (band_reg),
        .q_full          (q_full),
        .q_push          (q_push),
        .q_item          (push_item)
    );

    eno_queue u_queue
    (
        .clk       (clk),
        .rst_n     (rst_n),
        .push      (q_push),
        .push_item (push_item),
        .full      (q_full),
        .pop       (q_pop),
        .avail     (q_avail),
        .head      (head_item)
    );

    eno_back u_back
    (
        .clk             (clk),
        .rst_n           (rst_n),
        .q_avail         (q_avail),
        .q_head          (head_item),
        .q_pop           (q_pop),
        .inverse_spacing (inv_reg),
        .m_tvalid        (m_tvalid),
        .m_tready        (m_tready),
        .m_tdata         (m_tdata),
        .m_tuser         (m_tuser)
    );

endmodule

// ===== sim/eno_result_checker.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// eno_result_checker: advection term predictor and result comparator
// Watches the sample, result and configuration channels of the ENO upwind
// advection core. It keeps its own window and registers, predicts the rate
// term of every accepted sample, and compares results in order.
// ----------------------------------------------------------------------------
module eno_result_checker
(
    input  logic                                  clk,
    input  logic                                  rst_n,
    input  logic                                  s_tvalid,
    input  logic                                  s_tready,
    input  logic [3*eno_pkg::DataWidth-1:0]       s_tdata,   // phi_sample, velocity, band_distance
    input  logic                                  s_tuser,   // cell_valid
    input  logic                                  m_tvalid,
    input  logic                                  m_tready,
    input  logic [eno_pkg::DataWidth-1:0]         m_tdata,   // rate_term
    input  logic                                  m_tuser,   // in_band
    input  logic                                  cfg_we,
    input  logic [eno_pkg::CfgIdxWidth-1:0]       cfg_addr,
    input  logic [eno_pkg::InvWidth-1:0]          cfg_wdata,
    output int                                    terms_pending,
    output int                                    fail_count
);

    localparam int DW = eno_pkg::DataWidth;

    typedef struct {
        logic signed [DW-1:0] rate_term;
        logic                 in_band;
    } advect_term_t;

    longint                          phi_win [7];
    logic [1:0]                      order_reg;
    logic [eno_pkg::InvWidth-1:0]    inv_spacing_reg;
    logic [eno_pkg::BandWidth-1:0]   band_hw_reg;
    advect_term_t                    expected_terms [$];

    assign terms_pending = expected_terms.size();

    function automatic longint minmag(longint a, longint b);
        longint ma;
        longint mb;
        ma = (a < 0) ? -a : a;
        mb = (b < 0) ? -b : b;
        return (ma < mb) ? a : b;
    endfunction

    // floor(a * b / 2^FracBits), clamped to the range of a signed lim-bit value
    function automatic longint scale_sat(longint a, longint b, int lim);
        logic signed [127:0] pa;
        logic signed [127:0] pb;
        logic signed [127:0] q;
        logic signed [127:0] hi;
        logic signed [127:0] lo;
        pa = a;
        pb = b;
        q  = (pa * pb) >>> eno_pkg::FracBits;
        hi = (128'sd1 <<< (lim - 1)) - 1;
        lo = -(128'sd1 <<< (lim - 1));
        if (q > hi) q = hi;
        if (q < lo) q = lo;
        return longint'(q);
    endfunction

    // shift in one sample and work out the term of the centre cell
    function automatic advect_term_t predict_term(longint phi, longint vel, longint cell_dist,
                                                  logic valid);
        advect_term_t t;
        longint w0, w1, w2, w3, w4, w5, w6;
        longint n, l, r, d2mid, t3c, t3d, k, dq, deriv, dmag, ml, mr;
        bit up;
        for (int j = 0; j < 6; j++) phi_win[j] = phi_win[j+1];
        phi_win[6] = phi;
        {w0, w1, w2, w3, w4, w5, w6} = {phi_win[0], phi_win[1], phi_win[2], phi_win[3],
                                        phi_win[4], phi_win[5], phi_win[6]};
        dmag = (cell_dist < 0) ? -cell_dist : cell_dist;
        t.in_band = valid && (dmag <= longint'(band_hw_reg));
        t.rate_term = '0;
        if (!t.in_band) return t;
        up = vel > 0;
        d2mid = w2 - 2*w3 + w4;
        if (order_reg == 2) begin
            k = 2;
            if (up) n = 2*(w3 - w2) + minmag(w1 - 2*w2 + w3, d2mid);
            else    n = 2*(w4 - w3) - minmag(w3 - 2*w4 + w5, d2mid);
        end
        else if (order_reg == 3) begin
            k = 6;
            t3c = -w1 + 3*w2 - 3*w3 + w4;
            t3d = -w2 + 3*w3 - 3*w4 + w5;
            r = d2mid;
            mr = (r < 0) ? -r : r;
            if (up) begin
                l = w1 - 2*w2 + w3;
                ml = (l < 0) ? -l : l;
                n = 6*(w3 - w2);
                if (ml <= mr) n = n + 3*l + 2*minmag(-w0 + 3*w1 - 3*w2 + w3, t3c);
                else          n = n + 3*r - minmag(t3d, t3c);
            end
            else begin
                l = w3 - 2*w4 + w5;
                ml = (l < 0) ? -l : l;
                n = 6*(w4 - w3);
                if (ml <= mr) n = n - 3*l + 2*minmag(-w3 + 3*w4 - 3*w5 + w6, t3d);
                else          n = n - 3*r - minmag(t3c, t3d);
            end
        end
        else begin
            k = 1;
            n = up ? (w3 - w2) : (w4 - w3);
        end
        // round the division toward minus infinity
        dq = n / k;
        if ((n % k != 0) && (n < 0)) dq = dq - 1;
        deriv = scale_sat(dq, longint'(inv_spacing_reg), 64);
        t.rate_term = DW'(scale_sat(vel, deriv, DW));
        return t;
    endfunction

    // track registers, predict on each accepted sample, compare each result
    always @(posedge clk or negedge rst_n)
    begin
        advect_term_t got;
        advect_term_t want;
        if (!rst_n)
        begin
            for (int j = 0; j < 7; j++) phi_win[j] = 0;
            order_reg       = eno_pkg::OrderResetVal;
            inv_spacing_reg = eno_pkg::InvResetVal;
            band_hw_reg     = eno_pkg::BandResetVal;
            expected_terms.delete();
            fail_count      = 0;
        end
        else
        begin
            if (cfg_we)
            begin
                case (cfg_addr)
                    eno_pkg::CfgOrder:  order_reg       = cfg_wdata[1:0];
                    eno_pkg::CfgInvSpc: inv_spacing_reg = cfg_wdata;
                    eno_pkg::CfgBandHw: band_hw_reg     = cfg_wdata;
                    default:   ;
                endcase
            end
            if (s_tvalid && s_tready)
                expected_terms.push_back(predict_term(
                    longint'($signed(s_tdata[DW-1:0])),
                    longint'($signed(s_tdata[2*DW-1:DW])),
                    longint'($signed(s_tdata[3*DW-1:2*DW])),
                    s_tuser));
            if (m_tvalid && m_tready)
            begin
                got.rate_term = m_tdata;
                got.in_band   = m_tuser;
                if (expected_terms.size() == 0)
                begin
                    $error("result with no term pending: rate_term %0d in_band %0b",
                           got.rate_term, got.in_band);
                    fail_count++;
                end
                else
                begin
                    want = expected_terms.pop_front();
                    if (got.rate_term !== want.rate_term)
                    begin
                        $error("rate_term expected %0d actual %0d", want.rate_term,
                               got.rate_term);
                        fail_count++;
                    end
                    if (got.in_band !== want.in_band)
                    begin
                        $error("in_band expected %0b actual %0b", want.in_band, got.in_band);
                        fail_count++;
                    end
                end
            end
        end
    end

endmodule

// ===== sim/tb_eno_upwind_advection_stencil_core.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// tb_eno_upwind_advection_stencil_core: stream test of the ENO advection core
// Drives rows of level-set samples with random gaps and output stalls under a
// sequence of order, spacing and band settings; a checker predicts each term.
// ----------------------------------------------------------------------------
module tb_eno_upwind_advection_stencil_core;

    localparam int PhaseItems = 200;
    localparam int DW         = eno_pkg::DataWidth;
    localparam int IW         = eno_pkg::InvWidth;
    localparam int AW         = eno_pkg::CfgIdxWidth;
    // index past the register list, must be ignored
    localparam logic [AW-1:0] CfgNoReg = 2'd3;

    logic                          clk;
    logic                          rst_n;
    logic                          s_tvalid;
    logic                          s_tready;
    logic [3*DW-1:0]               s_tdata;   // phi_sample, velocity, band_distance
    logic                          s_tuser;   // cell_valid
    logic                          m_tvalid;
    logic                          m_tready;
    logic [DW-1:0]                 m_tdata;   // rate_term
    logic                          m_tuser;   // in_band
    logic                          cfg_we;
    logic [AW-1:0]                 cfg_addr;
    logic [IW-1:0]                 cfg_wdata;
    int                            terms_pending;
    int                            fail_count;
    int                            terms_taken;
    logic [eno_pkg::BandWidth-1:0] cur_band;

    eno_upwind_advection_stencil_core dut
    (
        .clk(clk), .rst_n(rst_n),
        .s_tvalid(s_tvalid), .s_tready(s_tready), .s_tdata(s_tdata), .s_tuser(s_tuser),
        .m_tvalid(m_tvalid), .m_tready(m_tready), .m_tdata(m_tdata), .m_tuser(m_tuser),
        .cfg_we(cfg_we), .cfg_addr(cfg_addr), .cfg_wdata(cfg_wdata)
    );

    eno_result_checker u_checker
    (
        .clk(clk), .rst_n(rst_n),
        .s_tvalid(s_tvalid), .s_tready(s_tready), .s_tdata(s_tdata), .s_tuser(s_tuser),
        .m_tvalid(m_tvalid), .m_tready(m_tready), .m_tdata(m_tdata), .m_tuser(m_tuser),
        .cfg_we(cfg_we), .cfg_addr(cfg_addr), .cfg_wdata(cfg_wdata),
        .terms_pending(terms_pending), .fail_count(fail_count)
    );

    initial clk = 1'b0;
    always #5 clk = ~clk;

    // hard stop well past the slowest correct run
    initial
    begin
        #30ms;
        $display("SCOREBOARD MISMATCH");
        $finish;
    end

    // offer one sample, after a random gap unless no_gap is set, and hold it until accepted
    task automatic send_sample(logic [31:0] phi, logic [31:0] vel, logic [31:0] band_d,
                               logic valid, bit no_gap);
        int gap;
        gap = no_gap ? 0 : $urandom_range(0, 16);
        if (gap > 0)
        begin
            s_tvalid <= 1'b0;
            repeat (gap) @(negedge clk);
        end
        s_tdata  <= {band_d, vel, phi};
        s_tuser  <= valid;
        s_tvalid <= 1'b1;
        @(posedge clk);
        while (!s_tready) @(posedge clk);
        @(negedge clk);
    endtask

    task automatic write_reg(logic [AW-1:0] idx, logic [IW-1:0] value);
        cfg_we    <= 1'b1;
        cfg_addr  <= idx;
        cfg_wdata <= value;
        @(negedge clk);
        cfg_we    <= 1'b0;
        if (idx == eno_pkg::CfgBandHw) cur_band = value;
    endtask

    // drain the core, then let the back end settle before new settings
    task automatic wait_idle();
        s_tvalid <= 1'b0;
        while (terms_pending != 0) @(negedge clk);
        repeat (150) @(negedge clk);
    endtask

    function automatic logic [31:0] pick_dist();
        logic [31:0] d;
        if ($urandom_range(0, 9) == 0) return $urandom;
        d = $urandom_range(0, cur_band);
        return $urandom_range(0, 1) ? -d : d;
    endfunction

    function automatic logic [31:0] pick_vel();
        case ($urandom_range(0, 5))
            0: return 32'd0;
            1, 2: return $urandom;
            default: return $signed($urandom_range(0, 32'h3_0000)) - 32'sh1_8000;
        endcase
    endfunction

    // one row: the first six samples valid only at random, the later samples valid
    task automatic send_row(bit no_gap, output int len);
        logic signed [31:0] phi;
        logic signed [31:0] slope;
        bit wild;
        len   = $urandom_range(7, 24);
        wild  = $urandom_range(0, 4) == 0;
        phi   = $signed($urandom_range(0, 32'h40_0000)) - 32'sh20_0000;
        slope = $signed($urandom_range(0, 32'h4_0000)) - 32'sh2_0000;
        for (int i = 0; i < len; i++)
        begin
            phi = wild ? $urandom
                       : phi + slope + ($signed($urandom_range(0, 32'h2000)) - 32'sh1000);
            if ($urandom_range(0, 15) == 0) slope = -slope;
            send_sample(phi, pick_vel(), pick_dist(),
                        (i >= 6) && (i < len) ? 1'b1 : ($urandom_range(0, 7) == 0), no_gap);
        end
    endtask

    task automatic run_phase(logic [1:0] order, logic [30:0] inv, logic [30:0] band);
        int sent;
        int row_len;
        bit no_gap;
        write_reg(eno_pkg::CfgOrder, order);
        write_reg(eno_pkg::CfgInvSpc, inv);
        write_reg(eno_pkg::CfgBandHw, band);
        sent = 0;
        while (sent < PhaseItems)
        begin
            no_gap = $urandom_range(0, 3) == 0;
            if ($urandom_range(0, 7) == 0)
            begin
                send_sample($urandom, $urandom, $urandom, $urandom_range(0, 1), no_gap);
                sent++;
            end
            else
            begin
                send_row(no_gap, row_len);
                sent += row_len;
            end
        end
        wait_idle();
    endtask

    // stimulus
    initial
    begin
        s_tvalid  = 1'b0;
        s_tdata   = '0;
        s_tuser   = 1'b0;
        cfg_we    = 1'b0;
        cfg_addr  = eno_pkg::CfgOrder;
        cfg_wdata = '0;
        cur_band  = eno_pkg::BandResetVal;
        rst_n     = 1'b0;
        repeat (8) @(posedge clk);
        @(negedge clk);
        rst_n     = 1'b1;
        @(negedge clk);

        // directed: extremes of samples, velocity, distance and validity
        send_sample(32'h7FFF_FFFF, 32'h0001_0000, 32'd0, 1'b1, 1'b0);
        send_sample(32'h8000_0000, 32'hFFFF_0000, 32'd0, 1'b1, 1'b0);
        send_sample(32'h7FFF_FFFF, 32'h7FFF_FFFF, 32'd196608, 1'b1, 1'b0);
        send_sample(32'h8000_0000, 32'h8000_0000, 32'hFFFD_0000, 1'b1, 1'b1);
        send_sample(32'h7FFF_FFFF, 32'd0, 32'd0, 1'b1, 1'b0);
        send_sample(32'h8000_0000, 32'h8000_0000, 32'h8000_0000, 1'b1, 1'b0);
        send_sample(32'h0000_0000, 32'h7FFF_FFFF, 32'h7FFF_FFFF, 1'b1, 1'b0);
        send_sample(32'hFFFF_FFFF, 32'h7FFF_FFFF, 32'd196609, 1'b1, 1'b0);
        send_sample(32'h0001_0000, 32'h8000_0000, 32'd0, 1'b0, 1'b0);
        wait_idle();
        write_reg(eno_pkg::CfgOrder, 2'd3);
        write_reg(eno_pkg::CfgInvSpc, 31'h7FFF_FFFF);
        for (int i = 0; i < 8; i++)
            send_sample(i[0] ? 32'h7FFF_FFFF : 32'h8000_0000,
                        i[1] ? 32'h7FFF_FFFF : 32'h8000_0000, 32'd0, 1'b1, 1'b0);
        wait_idle();
        write_reg(eno_pkg::CfgOrder, 2'd2);
        for (int i = 0; i < 4; i++)
            send_sample(i[0] ? 32'h7FFF_FFFF : 32'h8000_0000, i[1] ? 32'd1 : 32'hFFFF_FFFF,
                        32'd0, 1'b1, 1'b0);
        wait_idle();
        write_reg(CfgNoReg, 31'h5555_5555);

        // random phases across order, spacing and band settings
        run_phase(2'd1, 31'd65536, 31'd196608);
        run_phase(2'd2, 31'd65536, 31'h7FFF_FFFF);
        run_phase(2'd3, 31'd262144, 31'h7FFF_FFFF);
        run_phase(2'd3, 31'h7FFF_FFFF, 31'd0);
        run_phase(2'd0, 31'd1, 31'h7FFF_FFFF);
        run_phase(2'd2, 31'h7FFF_FFFF, 31'h7FFF_FFFF);
        run_phase(2'd3, 31'd65536, 31'd1048576);

        if (fail_count == 0 && terms_pending == 0)
            $display("SCOREBOARD CLEAN");
        else
            $display("SCOREBOARD MISMATCH");
        $finish;
    end

    // result side: random stalls, bursts with none, one long hold-off
    initial
    begin
        int stall;
        bit held;
        m_tready    = 1'b0;
        terms_taken = 0;
        held        = 1'b0;
        @(posedge rst_n);
        @(negedge clk);
        forever
        begin
            stall = ($urandom_range(0, 2) == 0) ? 0 : $urandom_range(0, 16);
            if (!held && terms_taken == 60)
            begin
                held  = 1'b1;
                stall = 600;
            end
            if (stall > 0)
            begin
                m_tready <= 1'b0;
                repeat (stall) @(negedge clk);
            end
            m_tready <= 1'b1;
            @(posedge clk);
            while (!m_tvalid) @(posedge clk);
            terms_taken++;
            @(negedge clk);
        end
    end

endmodule

// ===== files.f =====
rtl/eno_pkg.sv
rtl/eno_front.sv
rtl/eno_queue.sv
rtl/eno_back.sv
rtl/eno_upwind_advection_stencil_core.sv
sim/eno_result_checker.sv
sim/tb_eno_upwind_advection_stencil_core.sv
